[hdl/bqu_pkg.sv]
// Shared types and constants for the bilinear quad upsampler.
// Holds the quad, sample and descriptor structs and the reciprocal tables.
// No dependencies.
package bqu_pkg;

	localparam int RECIP_SHIFT = 29;

	typedef struct packed {
		logic signed [15:0] x_left;
		logic signed [15:0] x_right;
		logic signed [15:0] y_top;
		logic signed [15:0] y_bottom;
		logic [47:0]        corner_value_00;
		logic [47:0]        corner_value_01;
		logic [47:0]        corner_value_10;
		logic [47:0]        corner_value_11;
		logic               last_row;
		logic               last_col;
	} quad_t;

	typedef struct packed {
		logic [2:0]         column_in_block;
		logic [2:0]         row_in_block;
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic signed [15:0] value_x;
		logic signed [15:0] value_y;
		logic signed [15:0] value_z;
		logic               last_of_block;
	} sample_t;

	// Work item handed from the front to the back
	typedef struct packed {
		logic signed [15:0]    x_left;
		logic signed [15:0]    y_top;
		logic signed [16:0]    dx;
		logic signed [16:0]    dy;
		logic [3:0][2:0][15:0] corner;   // [00,01,10,11][x,y,z]
		logic [2:0]            col_last;
		logic [2:0]            row_last;
	} desc_t;

	// ceil(2^29 / d) for the coordinate step divisor d
	function automatic logic [29:0] recip_coord(input logic [2:0] d);
		logic [29:0] r;
		unique case (d)
			3'd2:    r = 30'd268435456;
			3'd3:    r = 30'd178956971;
			3'd4:    r = 30'd134217728;
			3'd5:    r = 30'd107374183;
			3'd6:    r = 30'd89478486;
			3'd7:    r = 30'd76695845;
			default: r = 30'd536870912;
		endcase
		return r;
	endfunction

	// ceil(2^29 / (2*d*d)) for the value rounding divisor
	function automatic logic [29:0] recip_value(input logic [2:0] d);
		logic [29:0] r;
		unique case (d)
			3'd2:    r = 30'd67108864;
			3'd3:    r = 30'd29826162;
			3'd4:    r = 30'd16777216;
			3'd5:    r = 30'd10737419;
			3'd6:    r = 30'd7456541;
			3'd7:    r = 30'd5478275;
			default: r = 30'd268435456;
		endcase
		return r;
	endfunction

endpackage

[hdl/bqu_front.sv]
// Front end: takes quads, derives spans, unpacks corners and sets the index limits.
// Uses bqu_pkg; feeds bqu_queue.
module bqu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     d,
	input  logic           quad_valid,
	output logic           quad_stall,
	input  bqu_pkg::quad_t quad,
	output logic           push,
	output bqu_pkg::desc_t desc,
	input  logic           full
);
	import bqu_pkg::*;

	logic  valid_s1;
	desc_t desc_s1;
	desc_t desc_next;
	logic  accept;

	always_comb begin
		desc_next.x_left = quad.x_left;
		desc_next.y_top  = quad.y_top;
		desc_next.dx = $signed({quad.x_right[15], quad.x_right})
		             - $signed({quad.x_left[15], quad.x_left});
		desc_next.dy = $signed({quad.y_bottom[15], quad.y_bottom})
		             - $signed({quad.y_top[15], quad.y_top});
		for (int m = 0; m < 3; m++) begin
			desc_next.corner[0][m] = quad.corner_value_00[16*m +: 16];
			desc_next.corner[1][m] = quad.corner_value_01[16*m +: 16];
			desc_next.corner[2][m] = quad.corner_value_10[16*m +: 16];
			desc_next.corner[3][m] = quad.corner_value_11[16*m +: 16];
		end
		// a last quad reaches the far edge index d
		desc_next.col_last = quad.last_col ? d : d - 3'd1;
		desc_next.row_last = quad.last_row ? d : d - 3'd1;
	end

	assign quad_stall = valid_s1 && full;
	assign push       = valid_s1 && !full;
	assign accept     = quad_valid && !quad_stall;
	assign desc       = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_next;
		end
	end

endmodule

[hdl/bqu_queue.sv]
// Two-entry queue of quad descriptors between the front and the back.
// Uses bqu_pkg.
module bqu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bqu_pkg::desc_t desc_in,
	output logic           full,
	input  logic           pop,
	output bqu_pkg::desc_t desc_out,
	output logic           valid
);
	import bqu_pkg::*;

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign desc_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= desc_in;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("pop from empty queue");

endmodule

[hdl/bqu_back.sv]
// Back end: walks the sample grid of each quad and computes coordinates and values.
// Five-stage pipeline with reciprocal division; uses bqu_pkg, reads bqu_queue.
module bqu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       d,
	input  logic             desc_valid,
	input  bqu_pkg::desc_t   desc,
	output logic             pop,
	output logic             sample_valid,
	input  logic             sample_stall,
	output bqu_pkg::sample_t sample
);
	import bqu_pkg::*;

	localparam int LANES = 5;   // x, y coordinates, then three value components

	// sequencer
	logic       busy_q;
	desc_t      cur_q;
	logic [2:0] i_q;
	logic [2:0] j_q;
	logic       adv;
	logic       issue;
	logic       last_issue;
	logic       load;

	logic [5:0] d2;
	logic [7:0] div_m;
	logic [2:0] wi0;
	logic [2:0] wj0;
	logic [3:0][5:0] w_next;

	// stage 1
	logic                  v_s1;
	logic [2:0]            i_s1;
	logic [2:0]            j_s1;
	logic                  last_s1;
	logic signed [15:0]    xl_s1;
	logic signed [15:0]    yt_s1;
	logic signed [16:0]    dx_s1;
	logic signed [16:0]    dy_s1;
	logic [3:0][2:0][15:0] corner_s1;
	logic [3:0][5:0]       w_s1;

	// stage 2
	logic               v_s2;
	logic [2:0]         i_s2;
	logic [2:0]         j_s2;
	logic               last_s2;
	logic signed [15:0] xl_s2;
	logic signed [15:0] yt_s2;
	logic signed [20:0] nx_s2;
	logic signed [20:0] ny_s2;
	logic signed [21:0] prod_s2 [4][3];

	// stage 3
	logic               v_s3;
	logic [2:0]         i_s3;
	logic [2:0]         j_s3;
	logic               last_s3;
	logic signed [15:0] xl_s3;
	logic signed [15:0] yt_s3;
	logic signed [23:0] num_s3 [LANES];
	logic signed [23:0] num_next [LANES];

	// stage 4
	logic               v_s4;
	logic [2:0]         i_s4;
	logic [2:0]         j_s4;
	logic               last_s4;
	logic signed [15:0] xl_s4;
	logic signed [15:0] yt_s4;
	logic signed [23:0] num_s4 [LANES];
	logic signed [23:0] q0_s4 [LANES];
	logic signed [23:0] q0_next [LANES];

	// stage 5 (output register)
	logic               out_valid_s5;
	sample_t            out_s5;
	logic signed [23:0] q_next [LANES];

	assign d2    = {3'b000, d} * {3'b000, d};
	assign div_m = {1'b0, d2, 1'b0};

	assign adv        = !(out_valid_s5 && sample_stall);
	assign issue      = busy_q && adv;
	assign last_issue = (i_q == cur_q.col_last) && (j_q == cur_q.row_last);
	assign load       = desc_valid && (!busy_q || (issue && last_issue));
	assign pop        = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= 3'd0;
			j_q    <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			i_q    <= 3'd0;
			j_q    <= 3'd0;
		end else if (issue) begin
			if (last_issue) begin
				busy_q <= 1'b0;
			end else if (i_q == cur_q.col_last) begin
				i_q <= 3'd0;
				j_q <= j_q + 3'd1;
			end else begin
				i_q <= i_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= desc;
		end
	end

	// corner weights: (d-i)(d-j), (d-i)j, i(d-j), ij
	always_comb begin
		wi0 = d - i_q;
		wj0 = d - j_q;
		w_next[0] = {3'b000, wi0} * {3'b000, wj0};
		w_next[1] = {3'b000, wi0} * {3'b000, j_q};
		w_next[2] = {3'b000, i_q} * {3'b000, wj0};
		w_next[3] = {3'b000, i_q} * {3'b000, j_q};
	end

	// weighted sums and 2*S + d*d
	always_comb begin
		logic signed [23:0] s;
		num_next[0] = {{3{nx_s2[20]}}, nx_s2};
		num_next[1] = {{3{ny_s2[20]}}, ny_s2};
		for (int m = 0; m < 3; m++) begin
			s = {{2{prod_s2[0][m][21]}}, prod_s2[0][m]}
			  + {{2{prod_s2[1][m][21]}}, prod_s2[1][m]}
			  + {{2{prod_s2[2][m][21]}}, prod_s2[2][m]}
			  + {{2{prod_s2[3][m][21]}}, prod_s2[3][m]};
			num_next[2 + m] = (s <<< 1) + $signed({18'b0, d2});
		end
	end

	// estimated quotient by reciprocal multiply; low by at most one
	always_comb begin
		logic signed [54:0] p;
		logic [29:0]        rc;
		for (int k = 0; k < LANES; k++) begin
			rc = (k < 2) ? recip_coord(d) : recip_value(d);
			p  = $signed({{31{num_s3[k][23]}}, num_s3[k]}) * $signed({25'b0, rc});
			q0_next[k] = p[RECIP_SHIFT + 23 : RECIP_SHIFT];
		end
	end

	// correct the quotient from the remainder
	always_comb begin
		logic signed [31:0] r;
		logic signed [31:0] dv;
		for (int k = 0; k < LANES; k++) begin
			dv = (k < 2) ? $signed({29'b0, d}) : $signed({24'b0, div_m});
			r  = $signed({{8{num_s4[k][23]}}, num_s4[k]})
			   - $signed({{8{q0_s4[k][23]}}, q0_s4[k]}) * dv;
			q_next[k] = q0_s4[k] + ((r >= dv) ? 24'sd1 : 24'sd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			out_valid_s5 <= 1'b0;
		end else if (adv) begin
			v_s1         <= issue;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			out_valid_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			i_s1      <= i_q;
			j_s1      <= j_q;
			last_s1   <= last_issue;
			xl_s1     <= cur_q.x_left;
			yt_s1     <= cur_q.y_top;
			dx_s1     <= cur_q.dx;
			dy_s1     <= cur_q.dy;
			corner_s1 <= cur_q.corner;
			w_s1      <= w_next;

			i_s2    <= i_s1;
			j_s2    <= j_s1;
			last_s2 <= last_s1;
			xl_s2   <= xl_s1;
			yt_s2   <= yt_s1;
			nx_s2   <= $signed({18'b0, i_s1}) * $signed({{4{dx_s1[16]}}, dx_s1});
			ny_s2   <= $signed({18'b0, j_s1}) * $signed({{4{dy_s1[16]}}, dy_s1});
			for (int k = 0; k < 4; k++) begin
				for (int m = 0; m < 3; m++) begin
					prod_s2[k][m] <= $signed({{6{corner_s1[k][m][15]}}, corner_s1[k][m]})
					               * $signed({16'b0, w_s1[k]});
				end
			end

			i_s3    <= i_s2;
			j_s3    <= j_s2;
			last_s3 <= last_s2;
			xl_s3   <= xl_s2;
			yt_s3   <= yt_s2;
			num_s3  <= num_next;

			i_s4    <= i_s3;
			j_s4    <= j_s3;
			last_s4 <= last_s3;
			xl_s4   <= xl_s3;
			yt_s4   <= yt_s3;
			num_s4  <= num_s3;
			q0_s4   <= q0_next;

			out_s5.column_in_block <= i_s4;
			out_s5.row_in_block    <= j_s4;
			out_s5.sample_x        <= xl_s4 + q_next[0][15:0];
			out_s5.sample_y        <= yt_s4 + q_next[1][15:0];
			out_s5.value_x         <= q_next[2][15:0];
			out_s5.value_y         <= q_next[3][15:0];
			out_s5.value_z         <= q_next[4][15:0];
			out_s5.last_of_block   <= last_s4;
		end
	end

	assign sample_valid = out_valid_s5;
	assign sample       = out_s5;

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (i_q <= cur_q.col_last) && (j_q <= cur_q.row_last))
		else $error("sample index beyond quad limits");
	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && (i_q == 3'd0) && (j_q == 3'd0))
		else $error("new quad does not start at the first sample");
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> desc_valid) else $error("quad taken from empty queue");

endmodule

[hdl/bilinear_quad_upsampler.sv]
// Bilinear quad upsampler: expands each quad into (D or D+1) by (D or D+1) samples, D = N+1.
// On an idle block, a quad passes the front register, the queue, the back sequencer and the back pipeline.
// Throughput: one sample per cycle from the back pipeline unless sample_stall holds it; a quad gives 1 to 64 samples.
// The front and a two-entry queue take the next quads while the back is still busy.
// Reset: asynchronous, active low; clears the queue and pipeline, sets N to 1.
// Uses bqu_pkg, bqu_front, bqu_queue, bqu_back.
module bilinear_quad_upsampler #(
	parameter int MAX_ADDED_POINTS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_data,
	input  logic             quad_valid,
	output logic             quad_stall,
	input  bqu_pkg::quad_t   quad,
	output logic             sample_valid,
	input  logic             sample_stall,
	output bqu_pkg::sample_t sample
);
	import bqu_pkg::*;

	logic [2:0] points_q;
	logic [2:0] n_eff;
	logic [2:0] d;
	logic       push;
	logic       full;
	logic       pop;
	logic       desc_valid;
	desc_t      desc_front;
	desc_t      desc_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= 3'd1;
		end else if (cfg_write) begin
			points_q <= cfg_data;
		end
	end

	// saturate N to the supported maximum
	assign n_eff = (points_q > 3'(MAX_ADDED_POINTS)) ? 3'(MAX_ADDED_POINTS) : points_q;
	assign d     = n_eff + 3'd1;

	bqu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.d          (d),
		.quad_valid (quad_valid),
		.quad_stall (quad_stall),
		.quad       (quad),
		.push       (push),
		.desc       (desc_front),
		.full       (full)
	);

	bqu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.desc_in  (desc_front),
		.full     (full),
		.pop      (pop),
		.desc_out (desc_head),
		.valid    (desc_valid)
	);

	bqu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.d            (d),
		.desc_valid   (desc_valid),
		.desc         (desc_head),
		.pop          (pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample)
	);

endmodule
